// ===== hdl/hsc_pkg.sv =====
// Package for the Hamming(8,4) SECDED byte codec: item types and code helpers.
`default_nettype none

package hsc_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned ByteW = 8;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [DataW-1:0] data_in;
  } hsc_in_t;

  typedef struct packed {
    logic [DataW-1:0] code_out;
    logic [ByteW-1:0] data_out;
    logic [DataW-1:0] error_mask;
    logic             uncorrectable;
  } hsc_out_t;

  // Result of checking one codeword
  typedef struct packed {
    logic             ok;
    logic [ByteW-1:0] word;
  } hsc_dec_res_t;

  // Bit of the codeword to flip for a given syndrome
  function automatic logic [ByteW-1:0] fix_bit(input logic [2:0] syn);
    logic [ByteW-1:0] m;
    case (syn)
      3'd1:    m = 8'h02;
      3'd2:    m = 8'h04;
      3'd3:    m = 8'h40;
      3'd4:    m = 8'h08;
      3'd5:    m = 8'h20;
      3'd6:    m = 8'h80;
      3'd7:    m = 8'h10;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hsc_enc.sv =====
// Encoder: one data byte into two Hamming(8,4) SECDED codewords.
`default_nettype none

module hsc_enc (
  input  wire logic [hsc_pkg::ByteW-1:0] data,
  output logic      [hsc_pkg::DataW-1:0] code
);
  import hsc_pkg::*;

  logic [ByteW-1:0] word_lo;
  logic [ByteW-1:0] word_hi;

  // Build one codeword per nibble
  function automatic logic [ByteW-1:0] enc_nibble(input logic [3:0] d);
    logic h0;
    logic h1;
    logic h2;
    logic p;
    h0 = d[0] ^ d[1] ^ d[2];
    h1 = d[0] ^ d[2] ^ d[3];
    h2 = d[0] ^ d[1] ^ d[3];
    p  = h0 ^ h1 ^ h2 ^ (^d);
    return {d, h2, h1, h0, p};
  endfunction

  always_comb begin
    word_lo = enc_nibble(data[3:0]);
    word_hi = enc_nibble(data[7:4]);
  end

  assign code = {word_hi, word_lo};

endmodule

`default_nettype wire

// ===== hdl/hsc_dec.sv =====
// Decoder for one codeword: syndrome, overall parity, single-bit repair.
`default_nettype none

module hsc_dec (
  input  wire logic [hsc_pkg::ByteW-1:0] word,
  output hsc_pkg::hsc_dec_res_t          res
);
  import hsc_pkg::*;

  logic       p;
  logic [2:0] syn;

  // Parity of bits 1..7 and the three check sums
  always_comb begin
    p      = ^word[7:1];
    syn[0] = word[1] ^ word[4] ^ word[5] ^ word[6];
    syn[1] = word[2] ^ word[4] ^ word[6] ^ word[7];
    syn[2] = word[3] ^ word[4] ^ word[5] ^ word[7];
  end

  // Repair parity bit alone, flag double errors, else flip the bad bit
  always_comb begin
    if (syn == 3'd0) begin
      res.ok   = 1'b1;
      res.word = {word[7:1], p};
    end else if (p == word[0]) begin
      res.ok   = 1'b0;
      res.word = '0;
    end else begin
      res.ok   = 1'b1;
      res.word = word ^ fix_bit(syn);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hamming_secded_byte_codec.sv =====
// Top level of the Hamming(8,4) SECDED byte codec.
// Data path: the input register, then the result register; the codec logic
// between them is combinational.
// Throughput: one item per cycle, limited only by downstream stall.
// Reset: synchronous rst clears both valid flags; payload registers keep data.
`default_nettype none

module hamming_secded_byte_codec (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  output logic                   src_stall,
  input  wire hsc_pkg::hsc_in_t  src_item,
  output logic                   dst_valid,
  input  wire logic              dst_stall,
  output hsc_pkg::hsc_out_t      dst_item
);
  import hsc_pkg::*;

  logic         stage_valid;
  hsc_in_t      stage_item;
  logic         stage_load;
  logic         out_load;
  logic [DataW-1:0] enc_code;
  hsc_dec_res_t dec_hi;
  hsc_dec_res_t dec_lo;
  hsc_out_t     result_next;

  // Advance when the next stage is empty or drains this cycle
  assign out_load   = !dst_valid || !dst_stall;
  assign src_stall  = stage_valid && !out_load;
  assign stage_load = src_valid && !src_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!stage_valid || out_load) begin
      stage_valid <= stage_load;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      stage_item <= src_item;
    end
  end

  hsc_enc u_enc (
    .data (stage_item.data_in[ByteW-1:0]),
    .code (enc_code)
  );

  hsc_dec u_dec_hi (
    .word (stage_item.data_in[DataW-1:ByteW]),
    .res  (dec_hi)
  );

  hsc_dec u_dec_lo (
    .word (stage_item.data_in[ByteW-1:0]),
    .res  (dec_lo)
  );

  // Select encode or decode result; on a double error zero the payload and flag it
  always_comb begin
    result_next = '0;
    if (stage_item.mode == MODE_ENCODE) begin
      result_next.code_out = enc_code;
    end else if (dec_hi.ok && dec_lo.ok) begin
      result_next.code_out   = {dec_hi.word, dec_lo.word};
      result_next.data_out   = {dec_hi.word[7:4], dec_lo.word[7:4]};
      result_next.error_mask = stage_item.data_in ^ {dec_hi.word, dec_lo.word};
    end else begin
      result_next.uncorrectable = 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_load) begin
      dst_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && stage_valid) begin
      dst_item <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hsc_check.sv =====
// Port checker for the SECDED byte codec, bound to the top level.
`default_nettype none

module hsc_check (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              dst_valid,
  input wire logic              dst_stall,
  input wire hsc_pkg::hsc_out_t dst_item
);
  import hsc_pkg::*;

  // Result transfer holds while stalled
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
    else $error("result changed while stalled");

  // Nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !dst_valid)
    else $error("result valid right after reset");

  // Double error zeroes all payload fields
  a_uncorr_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.uncorrectable |->
      dst_item.code_out == '0 && dst_item.data_out == '0 && dst_item.error_mask == '0)
    else $error("payload not cleared on double error");

  // Every emitted codeword has even overall parity
  a_even_parity: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> !(^dst_item.code_out[15:8]) && !(^dst_item.code_out[7:0]))
    else $error("codeword with odd parity");

  // Decoded data agrees with the data bits of the corrected codewords
  a_data_match: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.data_out != '0 |->
      dst_item.data_out == {dst_item.code_out[15:12], dst_item.code_out[7:4]})
    else $error("data byte does not match codewords");

endmodule

bind hamming_secded_byte_codec hsc_check u_hsc_check (
  .clk       (clk),
  .rst       (rst),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_item  (dst_item)
);

`default_nettype wire
